### hw/rtl/bmp_pkg.sv
`default_nettype none

package bmp_pkg;

    // Default geometry of the bitmap store.
    localparam int WORD_BITS_DEF  = 64;
    localparam int WORD_COUNT_DEF = 16;

    // Field widths of the request, response and configuration channels.
    localparam int CMD_W   = 3;
    localparam int WIDX_W  = 4;
    localparam int DATA_W  = 64;
    localparam int START_W = 10;
    localparam int COUNT_W = 11;
    localparam int TOTAL_W = 11;
    localparam int INDEX_W = 10;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);

    // Bit positions cover the largest store (256 words of 64 bits) plus one word.
    localparam int POS_W = 15;
    // Word numbers cover up to 256 words.
    localparam int IDX_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 3'd0,
        CMD_SET      = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_TEST     = 3'd3,
        CMD_TEST_ALL = 3'd4,
        CMD_START    = 3'd5,
        CMD_STEP     = 3'd6
    } bmp_cmd_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_SET,
        WR_WORD
    } bmp_wr_op_t;

    // Store update broadcast to every cell.
    typedef struct packed {
        bmp_wr_op_t          op;
        logic [WIDX_W-1:0]   index;
        logic [DATA_W-1:0]   data;
    } bmp_write_t;

    // Bit window of a sweep: lo is the first bit, hi the first bit past it.
    // Cells at or past hi take no part; use_hi also masks bits at or past hi.
    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             use_hi;
    } bmp_sweep_t;

    // Status handed from cell to cell during a sweep.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] last;
    } bmp_tag_t;

    typedef struct packed {
        logic               any_set;
        logic               found;
        logic [INDEX_W-1:0] bit_index;
        logic               range_error;
    } bmp_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/bmp_ifs.sv
`default_nettype none

// Command request channel.
interface bmp_req_if
    import bmp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [WIDX_W-1:0]  word_index;
    logic [DATA_W-1:0]  word_data;
    logic [START_W-1:0] range_start;
    logic [COUNT_W-1:0] range_len;

    modport source (
        output valid, cmd, word_index, word_data, range_start, range_len,
        input  ready
    );
    modport sink (
        input  valid, cmd, word_index, word_data, range_start, range_len,
        output ready
    );
endinterface

// Result channel.
interface bmp_rsp_if
    import bmp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               any_set;
    logic               found;
    logic [INDEX_W-1:0] bit_index;
    logic               range_error;

    modport source (
        output valid, any_set, found, bit_index, range_error,
        input  ready
    );
    modport sink (
        input  valid, any_set, found, bit_index, range_error,
        output ready
    );
endinterface

// Configuration write channel for the bit total register.
interface bmp_cfg_if
    import bmp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] bit_total;

    modport source (
        output valid, bit_total,
        input  ready
    );
    modport sink (
        input  valid, bit_total,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/bmp_cell.sv
`default_nettype none

module bmp_cell
    import bmp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CELL_ID   = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bmp_write_t           wr,
    input  wire bmp_sweep_t           sweep,
    input  wire bmp_tag_t             tag_in,
    input  wire logic [WORD_BITS-1:0] word_in,
    output bmp_tag_t                  tag_out,
    output logic [WORD_BITS-1:0]      word_out
);

    localparam int OFF_W = $clog2(WORD_BITS + 1);
    localparam logic [POS_W-1:0]     BASE     = POS_W'(CELL_ID * WORD_BITS);
    localparam logic [POS_W-1:0]     BASE_END = POS_W'((CELL_ID + 1) * WORD_BITS);
    localparam logic [IDX_W-1:0]     MY_IDX   = IDX_W'(CELL_ID);
    localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    bmp_tag_t             tag_reg;
    bmp_tag_t             tag_next;
    logic [WORD_BITS-1:0] carry_reg;
    logic [WORD_BITS-1:0] carry_next;

    logic [OFF_W-1:0]     lo_off;
    logic [OFF_W-1:0]     hi_off;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] masked;
    logic                 active;
    logic                 hit;

    // Store update: clear, set or a write addressed to this word.
    always_comb
    begin
        word_next = word_reg;
        unique case (wr.op)
            WR_NONE:  word_next = word_reg;
            WR_CLEAR: word_next = '0;
            WR_SET:   word_next = ONES;
            WR_WORD:
            begin
                if (IDX_W'(wr.index) == MY_IDX)
                begin
                    word_next = wr.data[WORD_BITS-1:0];
                end
            end
        endcase
    end

    // Clamp the window edges to this word's bit span.
    always_comb
    begin
        if (sweep.lo <= BASE)
        begin
            lo_off = '0;
        end
        else if (sweep.lo >= BASE_END)
        begin
            lo_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            lo_off = OFF_W'(sweep.lo - BASE);
        end

        if (sweep.hi <= BASE)
        begin
            hi_off = '0;
        end
        else if (sweep.hi >= BASE_END)
        begin
            hi_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            hi_off = OFF_W'(sweep.hi - BASE);
        end
    end

    assign lo_mask = ONES << lo_off;
    assign hi_mask = ~(ONES << hi_off);
    assign masked  = word_reg & lo_mask & (sweep.use_hi ? hi_mask : ONES);
    assign active  = BASE < sweep.hi;
    assign hit     = active && (|masked);

    // The first hit along the chain wins; later cells pass it on.
    always_comb
    begin
        tag_next   = tag_in;
        carry_next = word_in;
        if (active)
        begin
            tag_next.last = MY_IDX;
        end
        if (!tag_in.hit && hit)
        begin
            tag_next.hit = 1'b1;
            tag_next.pos = MY_IDX;
            carry_next   = masked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            tag_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            tag_reg  <= tag_next;
        end
    end

    // Carried word needs no reset: it only counts while the tag says hit.
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign tag_out  = tag_reg;
    assign word_out = carry_reg;

endmodule

`default_nettype wire

### hw/rtl/bmp_ctrl.sv
`default_nettype none

module bmp_ctrl
    import bmp_pkg::*;
#(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int WORD_COUNT = WORD_COUNT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bmp_cfg_if.sink                   cfg,
    bmp_req_if.sink                   req,
    bmp_rsp_if.source                 rsp,
    output bmp_write_t                wr,
    output bmp_sweep_t                sweep,
    input  wire bmp_tag_t             tail_tag,
    input  wire logic [WORD_BITS-1:0] tail_word
);

    localparam int PW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W = $clog2(WORD_COUNT + 1);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(WORD_COUNT);
    localparam logic [POS_W-1:0] CAPACITY = POS_W'(WORD_BITS * WORD_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_PICK,
        S_DONE
    } state_t;

    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    bmp_sweep_t           sweep_reg,     sweep_next;
    logic                 scan_mode_reg, scan_mode_next;
    logic [WORD_BITS-1:0] scan_word_reg, scan_word_next;
    logic [PW-1:0]        pos_reg,       pos_next;
    logic [TOTAL_W-1:0]   scan_end_reg,  scan_end_next;
    logic [TOTAL_W-1:0]   total_reg,     total_next;
    bmp_rsp_t             res_reg,       res_next;
    bmp_rsp_t             out_reg,       out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     start_ext;
    logic [POS_W-1:0]     end_ext;
    logic                 range_bad;
    logic [POS_W-1:0]     step_lo;
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     low_bit;
    logic [POS_W-1:0]     pick_idx;
    logic                 req_fire;

    // Bits in use: the register value saturated to the store size.
    assign total = (POS_W'(total_reg) > CAPACITY) ? CAPACITY : POS_W'(total_reg);

    assign start_ext = POS_W'(req.range_start);
    assign end_ext   = POS_W'(req.range_start) + POS_W'(req.range_len);
    assign range_bad = (req.range_len == '0) || (start_ext >= total) || (end_ext > total);

    // A step over an empty word searches from the next word on.
    assign step_lo = POS_W'((pos_reg + 1'b1) * WORD_BITS);

    // Lowest set bit of the pending scan word.
    assign iso = scan_word_reg & (~scan_word_reg + 1'b1);
    always_comb
    begin
        low_bit = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (iso[j])
            begin
                low_bit = low_bit | BIT_W'(j);
            end
        end
    end
    assign pick_idx = POS_W'(pos_reg * WORD_BITS) + POS_W'(low_bit);

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Command sequencing.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        scan_mode_next = scan_mode_reg;
        scan_word_next = scan_word_reg;
        pos_next       = pos_reg;
        scan_end_next  = scan_end_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        wr.op    = WR_NONE;
        wr.index = req.word_index;
        wr.data  = req.word_data;

        if (cfg.valid && cfg.ready)
        begin
            total_next = cfg.bit_total;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next       = '0;
                    state_next     = S_DONE;
                    cnt_next       = '0;
                    scan_mode_next = 1'b0;
                    unique case (bmp_cmd_t'(req.cmd))
                        CMD_CLEAR: wr.op = WR_CLEAR;
                        CMD_SET:   wr.op = WR_SET;
                        CMD_WRITE: wr.op = WR_WORD;
                        CMD_TEST:
                        begin
                            if (range_bad)
                            begin
                                res_next.range_error = 1'b1;
                            end
                            else
                            begin
                                sweep_next = '{lo: start_ext, hi: end_ext, use_hi: 1'b1};
                                state_next = S_SWEEP;
                            end
                        end
                        CMD_TEST_ALL:
                        begin
                            sweep_next = '{lo: '0, hi: total, use_hi: 1'b0};
                            state_next = S_SWEEP;
                        end
                        CMD_START:
                        begin
                            if (range_bad)
                            begin
                                res_next.range_error = 1'b1;
                                scan_word_next       = '0;
                                pos_next             = '0;
                                scan_end_next        = '0;
                            end
                            else
                            begin
                                sweep_next     = '{lo: start_ext, hi: end_ext, use_hi: 1'b0};
                                scan_end_next  = TOTAL_W'(end_ext);
                                scan_mode_next = 1'b1;
                                state_next     = S_SWEEP;
                            end
                        end
                        CMD_STEP:
                        begin
                            if (|scan_word_reg)
                            begin
                                state_next = S_PICK;
                            end
                            else
                            begin
                                sweep_next     = '{lo: step_lo, hi: POS_W'(scan_end_reg),
                                                   use_hi: 1'b0};
                                scan_mode_next = 1'b1;
                                state_next     = S_SWEEP;
                            end
                        end
                        default: res_next = '0;
                    endcase
                end
            end

            S_SWEEP:
            begin
                if (cnt_reg == CNT_DONE)
                begin
                    if (!scan_mode_reg)
                    begin
                        res_next.any_set = tail_tag.hit;
                        state_next       = S_DONE;
                    end
                    else if (tail_tag.hit)
                    begin
                        pos_next       = tail_tag.pos[PW-1:0];
                        scan_word_next = tail_word;
                        state_next     = S_PICK;
                    end
                    else
                    begin
                        // Nothing left: park on the last word of the range.
                        pos_next       = tail_tag.last[PW-1:0];
                        scan_word_next = '0;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_PICK:
            begin
                // Consume the lowest bit; past the range end it reports nothing.
                scan_word_next = scan_word_reg & (scan_word_reg - 1'b1);
                if (pick_idx < POS_W'(scan_end_reg))
                begin
                    res_next.found     = 1'b1;
                    res_next.bit_index = pick_idx[INDEX_W-1:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            scan_mode_reg <= 1'b0;
            scan_word_reg <= '0;
            pos_reg       <= '0;
            scan_end_reg  <= '0;
            total_reg     <= TOTAL_RESET;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sweep_reg     <= sweep_next;
            scan_mode_reg <= scan_mode_next;
            scan_word_reg <= scan_word_next;
            pos_reg       <= pos_next;
            scan_end_reg  <= scan_end_next;
            total_reg     <= total_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sweep           = sweep_reg;
    assign rsp.valid       = out_valid_reg;
    assign rsp.any_set     = out_reg.any_set;
    assign rsp.found       = out_reg.found;
    assign rsp.bit_index   = out_reg.bit_index;
    assign rsp.range_error = out_reg.range_error;

endmodule

`default_nettype wire

### hw/rtl/bitmap_range_test_and_set_bit_scan.sv
`default_nettype none

// Bitmap store of WORD_COUNT words of WORD_BITS bits with clear, set, word
// write, range test, test of all used words and a set-bit scan that returns
// one index per request. Every request gives exactly one result. The words
// sit in a row of cells; range tests and scan searches run as a sweep that
// moves one cell per clock from word 0 upward, and their result goes from the
// sweep state to the done state, through a pick state when a scan finds a bit,
// and then to the output register. Clear, set, word write and bad ranges go
// straight to the done state, and a scan step that still has bits left in its
// current word goes through the pick state only. A new request is taken in the
// cycle after the previous result has moved to the output register, which holds
// it until the consumer takes it, so the block handles one request at a time and
// waits out any output stall. The bit total register may be written only while
// no request is in flight.
module bitmap_range_test_and_set_bit_scan
    import bmp_pkg::*;
#(
    parameter int WORD_BITS  = WORD_BITS_DEF,
    parameter int WORD_COUNT = WORD_COUNT_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bmp_cfg_if.sink   cfg,
    bmp_req_if.sink   req,
    bmp_rsp_if.source rsp
);

    bmp_write_t           wr;
    bmp_sweep_t           sweep;
    bmp_tag_t             tag_chain  [WORD_COUNT+1];
    logic [WORD_BITS-1:0] word_chain [WORD_COUNT+1];

    // The chain starts with no hit.
    assign tag_chain[0]  = '0;
    assign word_chain[0] = '0;

    // Row of word cells.
    for (genvar i = 0; i < WORD_COUNT; i++)
    begin : g_cell
        bmp_cell #(
            .WORD_BITS (WORD_BITS),
            .CELL_ID   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr       (wr),
            .sweep    (sweep),
            .tag_in   (tag_chain[i]),
            .word_in  (word_chain[i]),
            .tag_out  (tag_chain[i+1]),
            .word_out (word_chain[i+1])
        );
    end

    // Request sequencing, scan state and result register.
    bmp_ctrl #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .wr        (wr),
        .sweep     (sweep),
        .tail_tag  (tag_chain[WORD_COUNT]),
        .tail_word (word_chain[WORD_COUNT])
    );

endmodule

`default_nettype wire

### bench/bitmap_range_test_and_set_bit_scan_test.sv
`timescale 1ns / 100ps

module bitmap_range_test_and_set_bit_scan_test
    import bmp_pkg::*;
();

    localparam int CLK_PERIOD     = 4;
    localparam int WBITS          = WORD_BITS_DEF;
    localparam int WCOUNT         = WORD_COUNT_DEF;
    localparam int CAP            = WBITS * WCOUNT;
    localparam int MAX_WAIT       = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 160;

    localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 3'd7;
    localparam logic [DATA_W-1:0] WORD_MASK   = {DATA_W{1'b1}} >> (DATA_W - WBITS);

    // One entry of the stimulus queue: a request, or a write of the bit total.
    typedef struct {
        bit                 is_cfg;
        logic [CMD_W-1:0]   cmd;
        logic [WIDX_W-1:0]  word_index;
        logic [DATA_W-1:0]  word_data;
        logic [START_W-1:0] range_start;
        logic [COUNT_W-1:0] range_len;
        logic [TOTAL_W-1:0] total;
    } bmp_item_t;

    logic clk = 1'b0;
    logic rst_n;

    bmp_req_if req_ch ();
    bmp_rsp_if rsp_ch ();
    bmp_cfg_if cfg_ch ();

    bitmap_range_test_and_set_bit_scan dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    bmp_item_t   cmd_queue[$];
    bmp_rsp_t    expected_rsp[$];
    int unsigned request_count = 0;
    int unsigned mismatches = 0;

    // Handshake flags seen at the last rising edge, used by the falling-edge drivers.
    bit req_took = 1'b0;
    bit rsp_took = 1'b0;
    bit cfg_took = 1'b0;
    bit req_up = 1'b0;
    bit cfg_up = 1'b0;

    // Shadow copy of the bitmap, the scan cursor and the bit total.
    logic [DATA_W-1:0] map_words [WCOUNT];
    logic [DATA_W-1:0] scan_bits;
    int unsigned       scan_pos;
    int unsigned       scan_stop;
    int unsigned       total_reg;

    function automatic int unsigned words_in(int unsigned n);
        return (n + WBITS - 1) / WBITS;
    endfunction

    // Bits of a word at and above the range start.
    function automatic logic [DATA_W-1:0] from_mask(int unsigned s);
        return (WORD_MASK << (s % WBITS)) & WORD_MASK;
    endfunction

    // Bits of the last word below the range end; a word-aligned end keeps the whole word.
    function automatic logic [DATA_W-1:0] upto_mask(int unsigned stop);
        int unsigned r;
        r = stop % WBITS;
        if (r == 0)
            return WORD_MASK;
        return {DATA_W{1'b1}} >> (DATA_W - r);
    endfunction

    function automatic bit range_bad(int unsigned s, int unsigned c, int unsigned tot);
        return c == 0 || s >= tot || s + c > tot;
    endfunction

    function automatic bit range_has_set(int unsigned s, int unsigned c);
        int unsigned stop, w, last;
        logic [DATA_W-1:0] lo_m, hi_m;
        stop = s + c;
        w = s / WBITS;
        last = (stop - 1) / WBITS;
        lo_m = from_mask(s);
        hi_m = upto_mask(stop);
        if (w == last)
            return (map_words[w] & lo_m & hi_m) != 0;
        if ((map_words[w] & lo_m) != 0)
            return 1'b1;
        for (w = w + 1; w < last; w++)
            if (map_words[w] != 0)
                return 1'b1;
        return (map_words[last] & hi_m) != 0;
    endfunction

    // Takes the lowest unreported set bit of the scan; bits past the end are used up.
    function automatic bit next_set_bit(output int unsigned idx);
        int unsigned nw, pos;
        nw = words_in(scan_stop);
        pos = 0;
        idx = 0;
        while (scan_bits == 0)
        begin
            if (scan_pos + 1 >= nw)
                return 1'b0;
            scan_pos++;
            scan_bits = map_words[scan_pos % WCOUNT] & WORD_MASK;
        end
        while (scan_bits[pos] == 1'b0)
            pos++;
        scan_bits[pos] = 1'b0;
        pos += scan_pos * WBITS;
        if (pos >= scan_stop)
            return 1'b0;
        idx = pos;
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns the result it should give.
    function automatic bmp_rsp_t predict_response(bmp_item_t op);
        bmp_rsp_t    r;
        int unsigned tot, s, c, hit, i;
        r = '0;
        tot = (total_reg > CAP) ? CAP : total_reg;
        s = op.range_start;
        c = op.range_len;
        case (op.cmd)
            CMD_CLEAR:
                for (i = 0; i < WCOUNT; i++)
                    map_words[i] = '0;
            CMD_SET:
                for (i = 0; i < WCOUNT; i++)
                    map_words[i] = WORD_MASK;
            CMD_WRITE:
                if (op.word_index < WCOUNT)
                    map_words[op.word_index] = op.word_data & WORD_MASK;
            CMD_TEST:
                if (range_bad(s, c, tot))
                    r.range_error = 1'b1;
                else
                    r.any_set = range_has_set(s, c);
            CMD_TEST_ALL:
                for (i = 0; i < words_in(tot); i++)
                    if (map_words[i] != 0)
                        r.any_set = 1'b1;
            CMD_START:
                if (range_bad(s, c, tot))
                begin
                    r.range_error = 1'b1;
                    scan_bits = '0;
                    scan_pos = 0;
                    scan_stop = 0;
                end
                else
                begin
                    scan_pos = s / WBITS;
                    scan_bits = map_words[scan_pos] & from_mask(s);
                    scan_stop = s + c;
                    if (next_set_bit(hit))
                    begin
                        r.found = 1'b1;
                        r.bit_index = INDEX_W'(hit);
                    end
                end
            CMD_STEP:
                if (next_set_bit(hit))
                begin
                    r.found = 1'b1;
                    r.bit_index = INDEX_W'(hit);
                end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Stimulus queue helpers.
    task automatic push_request(logic [CMD_W-1:0] op, logic [WIDX_W-1:0] widx,
                                logic [DATA_W-1:0] data, logic [START_W-1:0] s,
                                logic [COUNT_W-1:0] c);
        bmp_item_t e;
        e.is_cfg = 1'b0;
        e.cmd = op;
        e.word_index = widx;
        e.word_data = data;
        e.range_start = s;
        e.range_len = c;
        e.total = '0;
        cmd_queue.push_back(e);
        request_count++;
    endtask

    task automatic add_write(logic [WIDX_W-1:0] widx, logic [DATA_W-1:0] data);
        push_request(CMD_WRITE, widx, data, START_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic add_range(logic [CMD_W-1:0] op, int unsigned s, int unsigned c);
        push_request(op, WIDX_W'($urandom), {$urandom, $urandom}, START_W'(s), COUNT_W'(c));
    endtask

    task automatic add_plain(logic [CMD_W-1:0] op);
        push_request(op, WIDX_W'($urandom), {$urandom, $urandom}, START_W'($urandom),
                     COUNT_W'($urandom));
    endtask

    task automatic add_cfg(int unsigned setting);
        bmp_item_t e;
        e.is_cfg = 1'b1;
        e.cmd = '0;
        e.word_index = '0;
        e.word_data = '0;
        e.range_start = '0;
        e.range_len = '0;
        e.total = TOTAL_W'(setting);
        cmd_queue.push_back(e);
    endtask

    // Word contents: empty, full, dense random, sparse random or a few scattered bits.
    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        int unsigned n, k;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = {$urandom, $urandom};
            5: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default:
            begin
                w = '0;
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    w[$urandom_range(0, WBITS - 1)] = 1'b1;
            end
        endcase
        return w;
    endfunction

    // A legal range, biased toward word-aligned starts and ends and toward the top.
    task automatic pick_range(input int unsigned tot, output int unsigned s,
                              output int unsigned c);
        int unsigned stop;
        s = $urandom_range(0, tot - 1);
        if ($urandom_range(0, 3) == 0)
            s = (s / WBITS) * WBITS;
        case ($urandom_range(0, 3))
            0: c = tot - s;
            1: c = $urandom_range(1, (tot - s < 8) ? tot - s : 8);
            2:
            begin
                stop = (s / WBITS + 1 + $urandom_range(0, 3)) * WBITS;
                c = (stop > tot) ? tot - s : stop - s;
            end
            default: c = $urandom_range(1, tot - s);
        endcase
    endtask

    // Random traffic for one bit total: mostly fills, scans and range tests, some noise.
    task automatic add_phase(int unsigned setting, int unsigned n_items);
        int unsigned tot, s, c, n, k, goal;
        tot = (setting > CAP) ? CAP : setting;
        goal = request_count + n_items;
        while (request_count < goal)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        add_write(WIDX_W'($urandom_range(0, WCOUNT - 1)), pick_word());
                end
                2, 3, 4:
                begin
                    pick_range(tot, s, c);
                    add_range(CMD_START, s, c);
                    n = $urandom_range(1, 16);
                    for (k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            add_write(WIDX_W'($urandom_range(0, WCOUNT - 1)), pick_word());
                        add_plain(CMD_STEP);
                    end
                end
                5, 6:
                begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                    begin
                        pick_range(tot, s, c);
                        add_range(CMD_TEST, s, c);
                    end
                    // A range that runs one bit past the total.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        pick_range(tot, s, c);
                        add_range($urandom_range(0, 1) ? CMD_TEST : CMD_START, s, tot - s + 1);
                    end
                end
                7: add_plain(CMD_TEST_ALL);
                8:
                begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        push_request(CMD_W'($urandom_range(0, 7)), WIDX_W'($urandom),
                                     {$urandom, $urandom}, START_W'($urandom_range(0, 1023)),
                                     COUNT_W'($urandom_range(0, 2047)));
                end
                default: add_plain($urandom_range(0, 1) ? CMD_SET : CMD_CLEAR);
            endcase
        end
    endtask

    // Request and configuration driver: one item at a time, with random gaps.
    int unsigned gap_left = 0;
    int unsigned gap_limit = MAX_WAIT;

    always @(negedge clk)
    begin : drive
        bmp_item_t e;
        if (rst_n)
        begin
            if (req_took)
                req_up = 1'b0;
            if (cfg_took)
                cfg_up = 1'b0;
            if (!req_up && !cfg_up && cmd_queue.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!cmd_queue[0].is_cfg)
                begin
                    e = cmd_queue.pop_front();
                    req_ch.cmd <= e.cmd;
                    req_ch.word_index <= e.word_index;
                    req_ch.word_data <= e.word_data;
                    req_ch.range_start <= e.range_start;
                    req_ch.range_len <= e.range_len;
                    req_up = 1'b1;
                    gap_left = $urandom_range(0, gap_limit);
                    if ($urandom_range(0, 63) == 0)
                        gap_limit = $urandom_range(0, 1) ? MAX_WAIT : 0;
                end
                // The total is only written once every result is back.
                else if (expected_rsp.size() == 0)
                begin
                    e = cmd_queue.pop_front();
                    cfg_ch.bit_total <= e.total;
                    cfg_up = 1'b1;
                end
            end
            req_ch.valid <= req_up;
            cfg_ch.valid <= cfg_up;
        end
    end

    // Result consumer: random stalls, plus two long hold-offs that back up the block.
    int unsigned stall_left = 0;
    int unsigned stall_limit = MAX_WAIT;
    int unsigned hold_left = 0;
    int unsigned results_taken = 0;

    always @(negedge clk)
    begin : consume
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_took)
            begin
                results_taken++;
                if (results_taken == 500 || results_taken == 1300)
                    hold_left = HOLD_CYCLES;
                stall_left = $urandom_range(0, stall_limit);
                if ($urandom_range(0, 63) == 0)
                    stall_limit = $urandom_range(0, 1) ? MAX_WAIT : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: updates the shadow state on each accepted request and checks results in order.
    always @(posedge clk)
    begin : monitor
        bmp_item_t seen;
        bmp_rsp_t  want;
        int unsigned i;
        req_took <= rst_n && req_ch.valid && req_ch.ready;
        rsp_took <= rst_n && rsp_ch.valid && rsp_ch.ready;
        cfg_took <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (!rst_n)
        begin
            for (i = 0; i < WCOUNT; i++)
                map_words[i] = '0;
            scan_bits = '0;
            scan_pos = 0;
            scan_stop = 0;
            total_reg = TOTAL_RESET;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                total_reg = cfg_ch.bit_total;
            if (req_ch.valid && req_ch.ready)
            begin
                seen.is_cfg = 1'b0;
                seen.cmd = req_ch.cmd;
                seen.word_index = req_ch.word_index;
                seen.word_data = req_ch.word_data;
                seen.range_start = req_ch.range_start;
                seen.range_len = req_ch.range_len;
                seen.total = '0;
                expected_rsp.push_back(predict_response(seen));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("any_set", want.any_set, rsp_ch.any_set);
                    check_field("found", want.found, rsp_ch.found);
                    check_field("bit_index", want.bit_index, rsp_ch.bit_index);
                    check_field("range_error", want.range_error, rsp_ch.range_error);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : main
        int unsigned totals[$];
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.word_index = '0;
        req_ch.word_data = '0;
        req_ch.range_start = '0;
        req_ch.range_len = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.bit_total = TOTAL_RESET;
        rsp_ch.ready = 1'b0;

        // Directed part at the reset total: empty map, range edges, scan corner cases.
        add_plain(CMD_TEST_ALL);
        add_range(CMD_START, 0, 1024);
        add_write(0, 64'h21);
        add_write(5, 64'hF0);
        add_write(15, 64'h8000_0000_0000_0000);
        add_range(CMD_TEST, 1023, 1);
        add_range(CMD_TEST, 64, 256);
        add_range(CMD_TEST, 0, 0);
        add_range(CMD_TEST, 1000, 100);
        add_range(CMD_TEST, 0, 2047);
        // A bit past the scan end is used up and reported as none.
        add_range(CMD_START, 0, 2);
        add_plain(CMD_STEP);
        add_range(CMD_START, 1, 1023);
        add_plain(CMD_STEP);
        // A word written ahead of the scan is seen when the scan gets there.
        add_write(10, 64'h1);
        add_plain(CMD_STEP);
        add_plain(CMD_STEP);
        add_plain(CMD_STEP);
        add_plain(CMD_STEP);
        add_plain(CMD_STEP);
        // A bad start leaves nothing to scan.
        add_range(CMD_START, 0, 0);
        add_plain(CMD_SET);
        add_plain(CMD_TEST_ALL);
        add_plain(CMD_CLEAR);
        add_plain(CMD_UNKNOWN);

        // Random phases over several totals; steps right after a change continue the old scan.
        totals = '{1, 2047, 64, 65, 1023, 1024, 500, 63};
        totals.push_back($urandom_range(2, 1023));
        totals.push_back($urandom_range(2, 1023));
        foreach (totals[p])
        begin
            add_cfg(totals[p]);
            add_plain(CMD_STEP);
            add_plain(CMD_STEP);
            add_phase(totals[p], PHASE_ITEMS);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_queue.size() != 0 || req_up || cfg_up || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_ifs.sv
hw/rtl/bmp_cell.sv
hw/rtl/bmp_ctrl.sv
hw/rtl/bitmap_range_test_and_set_bit_scan.sv
bench/bitmap_range_test_and_set_bit_scan_test.sv
